// ----- src/assert_macros.svh -----
// Shared assertion macros; clk and rst_n must exist where they are used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, held off during reset.
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ----- src/pbed_pkg.sv -----
`default_nettype none

package pbed_pkg;

    localparam int IN_W  = 8;
    localparam int OUT_W = 96;
    localparam int CFG_W = 32;
    localparam int TIMEOUT_W = 16;

    localparam logic [TIMEOUT_W-1:0] RESET_IDLE_LIMIT = 16'd200;

    typedef enum logic
    {
        REG_IDLE_LIMIT  = 1'b0,
        REG_START_COUNT = 1'b1
    } reg_index_t;

    typedef struct packed
    {
        logic [31:0] entry_number;
        logic [31:0] idle_ms;
        logic [31:0] burst_ms;
    } record_t;

endpackage

`default_nettype wire

// ----- src/pulse_burst_entry_detector.sv -----
// A closing word's record is registered on acceptance: into the output slot if free or
// being read, else into the second slot. One input word per cycle while s_tready is high;
// the two result slots keep it high while one record waits; low only if both are full.
// Reset (rst_n low, asynchronous): time, burst state and entry count clear,
// the timeout returns to 200, start_count to 0, and both result slots empty.
`default_nettype none

module pulse_burst_entry_detector
    import pbed_pkg::*;
#(
    parameter int TIME_WIDTH = 32
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [IN_W-1:0]   s_tdata,   // [0] level, [1] tick, rest zero
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [OUT_W-1:0]       m_tdata,   // [31:0] burst_ms, [63:32] idle_ms,
                                              // [95:64] entry_number
    input  wire logic              wr_en,
    input  wire logic              wr_index,
    input  wire logic [CFG_W-1:0]  wr_data
);

    logic [TIMEOUT_W-1:0]  timeout_reg;
    logic [31:0]           start_count_reg;
    logic [TIME_WIDTH-1:0] now_reg;
    logic [TIME_WIDTH-1:0] start_reg;
    logic [TIME_WIDTH-1:0] fall_reg;
    logic                  active_reg;
    logic                  prev_reg;
    logic [31:0]           closed_reg;

    logic [TIME_WIDTH-1:0] now_next;
    logic [TIME_WIDTH-1:0] idle;
    logic [TIME_WIDTH-1:0] burst;
    logic [63:0]           idle_ext;
    logic [63:0]           burst_ext;
    logic [31:0]           closed_next;
    logic                  level;
    logic                  tick;
    logic                  edge_seen;
    logic                  close;
    logic                  accept;
    logic                  fire;
    logic                  pop;
    record_t               rec;

    record_t               out_reg;
    logic                  out_valid_reg;
    record_t               skid_reg;
    logic                  skid_valid_reg;

    assign level     = s_tdata[0];
    assign tick      = s_tdata[1];
    assign accept    = s_tvalid && s_tready;
    assign now_next  = tick ? now_reg + TIME_WIDTH'(1) : now_reg;
    assign edge_seen = level != prev_reg;
    assign idle      = now_next - fall_reg;
    assign burst     = fall_reg - start_reg;
    assign idle_ext  = 64'(idle);
    assign burst_ext = 64'(burst);
    assign closed_next = closed_reg + 32'd1;
    assign close     = !edge_seen && active_reg && !prev_reg
                       && (idle >= TIME_WIDTH'(timeout_reg));
    assign fire      = accept && close;
    assign pop       = out_valid_reg && m_tready;

    always_comb
    begin
        rec.burst_ms     = burst_ext[31:0];
        rec.idle_ms      = idle_ext[31:0];
        rec.entry_number = start_count_reg + closed_next;
    end

    assign s_tready = !skid_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg     <= RESET_IDLE_LIMIT;
            start_count_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (reg_index_t'(wr_index))
                REG_IDLE_LIMIT:  timeout_reg     <= wr_data[TIMEOUT_W-1:0];
                REG_START_COUNT: start_count_reg <= wr_data[31:0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            now_reg    <= '0;
            start_reg  <= '0;
            fall_reg   <= '0;
            active_reg <= 1'b0;
            prev_reg   <= 1'b0;
            closed_reg <= '0;
        end
        else if (accept)
        begin
            now_reg <= now_next;
            if (edge_seen)
            begin
                prev_reg <= level;
                if (!active_reg)
                begin
                    active_reg <= 1'b1;
                    start_reg  <= now_next;
                end
                if (!level)
                begin
                    fall_reg <= now_next;
                end
            end
            else if (close)
            begin
                active_reg <= 1'b0;
                closed_reg <= closed_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                if (!out_valid_reg || pop)
                begin
                    out_valid_reg <= 1'b1;
                end
                else
                begin
                    skid_valid_reg <= 1'b1;
                end
            end
            else if (pop)
            begin
                if (skid_valid_reg)
                begin
                    skid_valid_reg <= 1'b0;
                end
                else
                begin
                    out_valid_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && (!out_valid_reg || pop))
        begin
            out_reg <= rec;
        end
        else if (fire)
        begin
            skid_reg <= rec;
        end
        else if (pop && skid_valid_reg)
        begin
            out_reg <= skid_reg;
        end
    end

endmodule

`default_nettype wire

// ----- src/pbed_checker.sv -----
`default_nettype none
`include "assert_macros.svh"

module pbed_checker
    import pbed_pkg::*;
(
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             s_tvalid,
    input wire logic             s_tready,
    input wire logic             m_tvalid,
    input wire logic             m_tready,
    input wire logic [OUT_W-1:0] m_tdata
);

    `ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `ASSERT_IMPLY(a_stall_needs_full_out, !s_tready, m_tvalid)
    `ASSERT_IMPLY(a_record_needs_word, $rose(m_tvalid), $past(s_tvalid && s_tready))
    `ASSERT_IMPLY(a_empty_after_reset, $rose(rst_n), !m_tvalid)

endmodule

bind pulse_burst_entry_detector pbed_checker u_pbed_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
